// ===== rtl/stereo_audio_loopback_monitor_top_assert.svh =====
// Assertion macros for the loopback monitor checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef STEREO_AUDIO_LOOPBACK_MONITOR_TOP_ASSERT_SVH
`define STEREO_AUDIO_LOOPBACK_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SALM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SALM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/salm_pkg.sv =====
// Package for the stereo loopback monitor: widths, reset values, codes and types.
// Used by salm_div, the top level and the checker; depends on nothing.
package salm_pkg;

  localparam int DEFAULT_SAMPLE_BITS = 16;
  localparam int WINDOW_W  = 18;
  localparam int THRESH_W  = 16;
  localparam int COUNT_W   = 18;
  localparam int PCT_W     = 14;
  localparam int FREQ_W    = 17;
  localparam int NUM_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int GATE_W    = COUNT_W + 5;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 18'd48000;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd64;
  localparam logic [PCT_W-1:0]    PCT_SCALE    = 14'd10000;
  localparam logic [PCT_W-1:0]    PCT_MAX      = 14'd10000;
  localparam logic [FREQ_W-1:0]   FREQ_MAX     = 17'h1FFFF;
  // Loud share above 5 percent: loud * 20 > frames.
  localparam logic [4:0]          GATE_RATIO   = 5'd20;
  // Truncated percentage below this means the frequency gate is closed.
  localparam logic [PCT_W-1:0]    GATE_PCT     = 14'd500;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOUD_THRESHOLD = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_SCALE,
    S_DIV_SIG_GO,
    S_DIV_SIG_WAIT,
    S_DIV_MIS_GO,
    S_DIV_MIS_WAIT,
    S_REPORT
  } state_t;

  // Status of the serial divider toward its user.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/stereo_audio_loopback_monitor_top.sv =====
// Stereo loopback monitor top level: bit-serial frame scan, window counters, report.
// Depends on salm_pkg and instantiates salm_div.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+--------------------------------------------------
//   in      | in_valid / in_ready  | left_sample, right_sample
//   out     | out_valid / out_ready| signal_pct_x100, mismatch_pct_x100, freq_estimate
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (cfg_ready is always high)
//
// A frame passes through the accepting idle state, a scan of one bit per cycle over
// max(SAMPLE_BITS + 1, 16) bits, and an evaluation state that updates the counters.
// The frame that closes a window adds two serial divisions and their control states.
// in_ready is high only in the idle state. A report waiting in the output register
// holds back the next report, and frames with it, until it is taken. Reset is
// synchronous and restores the defaults.
module stereo_audio_loopback_monitor_top #(
  parameter int SAMPLE_BITS = salm_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [salm_pkg::PCT_W-1:0]    signal_pct_x100,
  output logic [salm_pkg::PCT_W-1:0]    mismatch_pct_x100,
  output logic [salm_pkg::FREQ_W-1:0]   freq_estimate,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [salm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salm_pkg::WINDOW_W-1:0]  cfg_data
);
  import salm_pkg::*;

  localparam int MAG_W  = SAMPLE_BITS + 1;
  localparam int SCAN_W = (MAG_W > THRESH_W) ? MAG_W : THRESH_W;
  localparam int BIT_W  = $clog2(SCAN_W);

  state_t state, state_next;

  // Configuration registers.
  logic [WINDOW_W-1:0] window_frames;
  logic [THRESH_W-1:0] loud_threshold;

  // Window counters and carried-over sample memory.
  logic [COUNT_W-1:0] frame_count;
  logic [COUNT_W-1:0] loud_count;
  logic [COUNT_W-1:0] mismatch_count;
  logic [FREQ_W-1:0]  crossing_count;
  logic               last_loud;
  logic               prev_nonpos;

  // Serial scan registers.
  logic [SCAN_W-1:0] sh_left;
  logic [SCAN_W-1:0] sh_right;
  logic [SCAN_W-1:0] sh_thr;
  logic [BIT_W-1:0]  bit_cnt;
  logic              l_neg, r_neg;
  logic              l_one, r_one;
  logic              ge_l, ge_r;
  logic              differ;
  logic              l_nz;

  // Window snapshot and report staging.
  logic [COUNT_W-1:0] snap_frames;
  logic [COUNT_W-1:0] snap_loud;
  logic [COUNT_W-1:0] snap_mis;
  logic [FREQ_W-1:0]  snap_cross;
  logic [NUM_W-1:0]   div_num;
  logic [PCT_W-1:0]   sig_pct;
  logic [PCT_W-1:0]   mis_pct;
  logic [FREQ_W-1:0]  freq;

  logic [PCT_W-1:0] div_quot;
  div_stat_t        div_stat;
  logic             div_start;

  // Per-bit scan logic.
  logic lb, rb, tb, mag_l, mag_r;
  // End-of-frame evaluation.
  logic               loud, left_pos, crossing;
  logic [COUNT_W-1:0] frame_inc, loud_inc, mis_inc, limit;
  logic [FREQ_W-1:0]  cross_inc;
  logic               close;
  logic [GATE_W-1:0]  gate_lhs;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign div_start = (state == S_DIV_SIG_GO) || (state == S_DIV_MIS_GO);

  // Magnitudes are formed serially: copy bits through the first one, then invert.
  always_comb begin
    lb    = sh_left[0];
    rb    = sh_right[0];
    tb    = sh_thr[0];
    mag_l = l_neg ? (lb ^ l_one) : lb;
    mag_r = r_neg ? (rb ^ r_one) : rb;
  end

  // Frame classification and counter increments.
  always_comb begin
    loud      = ge_l || ge_r;
    left_pos  = !l_neg && l_nz;
    crossing  = last_loud && loud && prev_nonpos && left_pos;
    frame_inc = frame_count + 1'b1;
    loud_inc  = loud_count + COUNT_W'(loud);
    mis_inc   = mismatch_count + COUNT_W'(differ);
    cross_inc = (crossing && crossing_count != FREQ_MAX) ? crossing_count + 1'b1
                                                         : crossing_count;
    limit     = (window_frames == '0) ? COUNT_W'(1) : window_frames;
    close     = frame_inc >= limit;
    gate_lhs  = GATE_W'(snap_loud) * GATE_W'(GATE_RATIO);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:         if (in_valid) state_next = S_SCAN;
      S_SCAN:         if (bit_cnt == BIT_W'(SCAN_W - 1)) state_next = S_EVAL;
      S_EVAL:         state_next = close ? S_SCALE : S_IDLE;
      S_SCALE:        state_next = S_DIV_SIG_GO;
      S_DIV_SIG_GO:   state_next = S_DIV_SIG_WAIT;
      S_DIV_SIG_WAIT: if (div_stat.done) state_next = S_DIV_MIS_GO;
      S_DIV_MIS_GO:   state_next = S_DIV_MIS_WAIT;
      S_DIV_MIS_WAIT: if (div_stat.done) state_next = S_REPORT;
      S_REPORT:       if (!out_valid || out_ready) state_next = S_IDLE;
      default:        state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_frames  <= WINDOW_RESET;
      loud_threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_FRAMES:  window_frames  <= cfg_data;
        REG_LOUD_THRESHOLD: loud_threshold <= cfg_data[THRESH_W-1:0];
        default:            ;
      endcase
    end
  end

  // Serial scan: load on acceptance, then one bit per cycle.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      sh_left  <= SCAN_W'(left_sample);
      sh_right <= SCAN_W'(right_sample);
      sh_thr   <= SCAN_W'(loud_threshold);
      l_neg    <= left_sample[SAMPLE_BITS-1];
      r_neg    <= right_sample[SAMPLE_BITS-1];
      l_one    <= 1'b0;
      r_one    <= 1'b0;
      ge_l     <= 1'b1;
      ge_r     <= 1'b1;
      differ   <= 1'b0;
      l_nz     <= 1'b0;
      bit_cnt  <= '0;
    end else if (state == S_SCAN) begin
      sh_left  <= sh_left >> 1;
      sh_right <= sh_right >> 1;
      sh_thr   <= sh_thr >> 1;
      l_one    <= l_one || lb;
      r_one    <= r_one || rb;
      if (mag_l != tb) ge_l <= mag_l;
      if (mag_r != tb) ge_r <= mag_r;
      differ   <= differ || (lb ^ rb);
      l_nz     <= l_nz || lb;
      bit_cnt  <= bit_cnt + 1'b1;
    end
  end

  // Window counters; the closing frame moves them into the snapshot.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count    <= '0;
      loud_count     <= '0;
      mismatch_count <= '0;
      crossing_count <= '0;
      last_loud      <= 1'b0;
      prev_nonpos    <= 1'b1;
    end else if (state == S_EVAL) begin
      last_loud   <= loud;
      prev_nonpos <= l_neg || !l_nz;
      if (close) begin
        frame_count    <= '0;
        loud_count     <= '0;
        mismatch_count <= '0;
        crossing_count <= '0;
      end else begin
        frame_count    <= frame_inc;
        loud_count     <= loud_inc;
        mismatch_count <= mis_inc;
        crossing_count <= cross_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL && close) begin
      snap_frames <= frame_inc;
      snap_loud   <= loud_inc;
      snap_mis    <= mis_inc;
      snap_cross  <= cross_inc;
    end
  end

  // Report staging: scale numerators, gate the frequency, collect quotients.
  always_ff @(posedge clk) begin
    unique case (state)
      S_SCALE: begin
        div_num <= NUM_W'(snap_loud) * NUM_W'(PCT_SCALE);
        freq    <= (gate_lhs > GATE_W'(snap_frames)) ? snap_cross : '0;
      end
      S_DIV_SIG_WAIT: begin
        if (div_stat.done) begin
          sig_pct <= div_quot;
          div_num <= NUM_W'(snap_mis) * NUM_W'(PCT_SCALE);
        end
      end
      S_DIV_MIS_WAIT: begin
        if (div_stat.done) mis_pct <= div_quot;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_REPORT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_REPORT && (!out_valid || out_ready)) begin
      signal_pct_x100   <= sig_pct;
      mismatch_pct_x100 <= mis_pct;
      freq_estimate     <= freq;
    end
  end

  salm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (snap_frames),
    .quot  (div_quot),
    .stat  (div_stat)
  );

endmodule

// ===== rtl/salm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on salm_pkg for widths and the status struct.
module salm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [salm_pkg::NUM_W-1:0]   num,
  input  logic [salm_pkg::COUNT_W-1:0] den,
  output logic [salm_pkg::PCT_W-1:0]   quot,
  output salm_pkg::div_stat_t          stat
);
  import salm_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  num_sh;
  logic [COUNT_W-1:0] den_reg;
  logic [COUNT_W-1:0] rem;
  logic [PCT_W-1:0]  q;

  logic [COUNT_W:0]   trial;
  logic               fits;
  logic [COUNT_W-1:0] rem_next;

  // One restoring step: bring down the next numerator bit and try a subtract.
  always_comb begin
    trial    = {rem, num_sh[NUM_W-1]};
    fits     = trial >= {1'b0, den_reg};
    rem_next = fits ? COUNT_W'(trial - {1'b0, den_reg}) : trial[COUNT_W-1:0];
  end

  // Control: busy while stepping through all NUM_W numerator bits after start, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath. The quotient fits in PCT_W bits, so high bits shift out as zeros.
  always_ff @(posedge clk) begin
    if (!busy && start) begin
      num_sh  <= num;
      den_reg <= den;
      rem     <= '0;
      q       <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem    <= rem_next;
      q      <= {q[PCT_W-2:0], fits};
    end
  end

  assign quot      = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/salm_checker.sv =====
// Port-level checker for the stereo loopback monitor, bound to the top level.
// Depends on salm_pkg and the assertion macro header.
module salm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [salm_pkg::PCT_W-1:0]  signal_pct_x100,
  input logic [salm_pkg::PCT_W-1:0]  mismatch_pct_x100,
  input logic [salm_pkg::FREQ_W-1:0] freq_estimate
);
  import salm_pkg::*;
  `include "stereo_audio_loopback_monitor_top_assert.svh"

  // A stalled report keeps its transaction unchanged.
  `SALM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(signal_pct_x100) && $stable(mismatch_pct_x100) && $stable(freq_estimate), "stalled report changed")

  // Percentages never exceed one hundred percent.
  `SALM_ASSERT_NOW(a_pct_range, out_valid, signal_pct_x100 <= PCT_MAX && mismatch_pct_x100 <= PCT_MAX, "percentage out of range")

  // A quiet window reports no frequency.
  `SALM_ASSERT_NOW(a_freq_gate, out_valid && signal_pct_x100 < GATE_PCT, freq_estimate == '0, "frequency reported for quiet window")

  // An accepted frame keeps the block busy in the following cycle.
  `SALM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "frame accepted back to back")

endmodule

bind stereo_audio_loopback_monitor_top salm_checker u_salm_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .signal_pct_x100   (signal_pct_x100),
  .mismatch_pct_x100 (mismatch_pct_x100),
  .freq_estimate     (freq_estimate)
);
